### rtl/chd_pkg.sv
// Shared types, constants and character helpers for the chunked body decoder.
// No dependencies; imported by chd_step, chd_out and http_chunked_body_decoder.
`default_nettype none

package chd_pkg;

    // Width of the chunk size and remaining byte count.
    localparam int SIZE_W = 31;

    // Result kinds.
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    // Characters that steer the parser.
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    // Hex digits are four bits each, so one digit scales the size by 16.
    localparam int DIGIT_W = 4;

    // One result word between the step logic and the output register.
    typedef struct packed {
        logic       valid;
        logic [7:0] byte_out;
        logic [1:0] kind;
    } t_result;

    // Decoded hex digit.
    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    function automatic t_hex hex_value(input logic [7:0] c);
        t_hex h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.val = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            // 'a'..'f' and 'A'..'F' share the low nibble 1..6.
            h.val = c[3:0] + 4'd9;
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

    // Space, TAB, VT, FF and CR count as blanks before the digits.
    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C) || (c == CH_CR);
    endfunction

endpackage

`default_nettype wire

### rtl/http_chunked_body_decoder.sv
// HTTP/1.1 chunked body decoder: input word register, parser step, output register.
// Depends on chd_pkg, chd_step and chd_out.
//
// Usage: raw body bytes enter on i_valid/i_byte_in, one word per accepted
// handshake (i_valid high, o_stall low). Results leave on o_valid with
// o_byte_out and o_kind: kind 0 is a payload byte, kind 1 marks end of body
// and is the last result, kind 2 reports an empty or overlong size line.
// Size lines, CRLF after each chunk and the trailer produce no result.
// A byte accepted into the input register is parsed from there by the parser
// step, and its result is registered in the output register, which drives
// o_valid until the receiver takes the word from the output register.
// Throughput: one byte per cycle while the receiver does not stall, since
// the parser step between the input and the output register is combinational.
// When the receiver holds i_stall high with a result waiting, the parser
// stops and o_stall rises while a byte is held in the input register; both
// sides run again in the cycle the stall drops.
// Reset (i_rst_n low at a clock edge) empties both registers and returns
// the parser to the start of a size line.
`default_nettype none

module http_chunked_body_decoder
    import chd_pkg::*;
#(
    parameter int HEADER_LINE_MAX = 23
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_byte_in,
    output logic            o_stall,
    output logic            o_valid,
    output logic [7:0]      o_byte_out,
    output logic [1:0]      o_kind,
    input  wire logic       i_stall
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       out_ready;
    logic       step_en;
    logic       in_accept;
    t_result    res;

    // The parser runs whenever a byte is held and the output can take a word.
    assign step_en   = r_in_valid && out_ready;
    assign o_stall   = r_in_valid && !out_ready;
    assign in_accept = i_valid && !o_stall;

    // Input word register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (step_en) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_byte_in;
        end
    end

    chd_step #(
        .HEADER_LINE_MAX(HEADER_LINE_MAX)
    ) u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (step_en),
        .i_byte  (r_in_byte),
        .o_res   (res)
    );

    chd_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_res      (res),
        .i_stall    (i_stall),
        .o_ready    (out_ready),
        .o_valid    (o_valid),
        .o_byte_out (o_byte_out),
        .o_kind     (o_kind)
    );

endmodule

`default_nettype wire

### rtl/chd_step.sv
// Parser state and the one-byte update of the chunked decoder.
// Depends on chd_pkg; produces at most one valid t_result word per processed byte.
`default_nettype none

module chd_step
    import chd_pkg::*;
#(
    parameter int HEADER_LINE_MAX = 23
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_en,
    input  wire logic [7:0] i_byte,
    output t_result         o_res
);

    localparam int LEN_W = $clog2(HEADER_LINE_MAX + 1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(HEADER_LINE_MAX);

    typedef enum logic [2:0] {
        PH_SIZE, PH_DATA, PH_GAP1, PH_GAP2, PH_TRAILER, PH_DONE, PH_DISCARD
    } t_phase;

    typedef enum logic [1:0] {
        HX_BLANK, HX_ZERO, HX_DIGIT, HX_STOP
    } t_hexst;

    t_phase            r_phase, n_phase;
    t_hexst            r_hex, n_hex;
    logic [SIZE_W-1:0] r_bytes, n_bytes;
    logic [LEN_W-1:0]  r_len, n_len;
    logic              r_trail_cr, n_trail_cr;

    t_hex              hv;
    logic [SIZE_W-1:0] added;
    logic [SIZE_W-1:0] dec;

    // Size accumulation saturates once another digit would overflow.
    assign hv    = hex_value(i_byte);
    assign added = (r_bytes[SIZE_W-1 -: DIGIT_W] != '0) ? '1
                 : {r_bytes[SIZE_W-DIGIT_W-1:0], hv.val};
    assign dec   = r_bytes - SIZE_W'(1);

    // Next state and result for the byte at the input register.
    always_comb begin
        n_phase    = r_phase;
        n_hex      = r_hex;
        n_bytes    = r_bytes;
        n_len      = r_len;
        n_trail_cr = r_trail_cr;
        o_res      = '0;
        if (i_en) begin
            case (r_phase)
                PH_SIZE: begin
                    if (i_byte == CH_LF) begin
                        n_len = '0;
                        n_hex = HX_BLANK;
                        if (r_len == '0) begin
                            // Empty size line.
                            n_bytes     = '0;
                            o_res.valid = 1'b1;
                            o_res.kind  = KIND_ERR;
                        end else begin
                            n_trail_cr = 1'b0;
                            n_phase    = (r_bytes == '0) ? PH_TRAILER : PH_DATA;
                        end
                    end else if (r_len >= LEN_MAX) begin
                        // Overlong size line: drop the rest of it.
                        n_bytes     = '0;
                        n_len       = '0;
                        n_hex       = HX_BLANK;
                        n_phase     = PH_DISCARD;
                        o_res.valid = 1'b1;
                        o_res.kind  = KIND_ERR;
                    end else begin
                        n_len = r_len + LEN_W'(1);
                        case (r_hex)
                            HX_BLANK: begin
                                if (!is_blank(i_byte)) begin
                                    if (i_byte == 8'h30) begin
                                        n_hex = HX_ZERO;
                                    end else if (hv.ok) begin
                                        n_bytes = added;
                                        n_hex   = HX_DIGIT;
                                    end else begin
                                        n_hex = HX_STOP;
                                    end
                                end
                            end
                            HX_ZERO: begin
                                if (i_byte == 8'h78 || i_byte == 8'h58) begin
                                    n_hex = HX_DIGIT;
                                end else if (hv.ok) begin
                                    n_bytes = added;
                                    n_hex   = HX_DIGIT;
                                end else begin
                                    n_hex = HX_STOP;
                                end
                            end
                            HX_DIGIT: begin
                                if (hv.ok) begin
                                    n_bytes = added;
                                end else begin
                                    n_hex = HX_STOP;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                PH_DATA: begin
                    n_bytes        = dec;
                    o_res.valid    = 1'b1;
                    o_res.byte_out = i_byte;
                    o_res.kind     = KIND_DATA;
                    if (dec == '0) begin
                        n_phase = PH_GAP1;
                    end
                end
                PH_GAP1: begin
                    n_phase = PH_GAP2;
                end
                PH_GAP2: begin
                    n_bytes = '0;
                    n_len   = '0;
                    n_hex   = HX_BLANK;
                    n_phase = PH_SIZE;
                end
                PH_TRAILER: begin
                    if (i_byte == CH_LF) begin
                        n_len      = '0;
                        n_trail_cr = 1'b0;
                        if (r_len == '0 || r_trail_cr) begin
                            n_phase     = PH_DONE;
                            o_res.valid = 1'b1;
                            o_res.kind  = KIND_END;
                        end
                    end else begin
                        if (r_len == '0 && i_byte == CH_CR) begin
                            n_trail_cr = 1'b1;
                        end
                        if (r_len < LEN_MAX) begin
                            n_len = r_len + LEN_W'(1);
                        end
                    end
                end
                PH_DISCARD: begin
                    if (i_byte == CH_LF) begin
                        n_bytes = '0;
                        n_len   = '0;
                        n_hex   = HX_BLANK;
                        n_phase = PH_SIZE;
                    end
                end
                default: begin
                    // End of body: every later byte is ignored.
                end
            endcase
        end
    end

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_SIZE;
            r_hex      <= HX_BLANK;
            r_bytes    <= '0;
            r_len      <= '0;
            r_trail_cr <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_hex      <= n_hex;
            r_bytes    <= n_bytes;
            r_len      <= n_len;
            r_trail_cr <= n_trail_cr;
        end
    end

    // A chunk in progress always has bytes left to pass.
    a_data_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DATA |-> r_bytes != '0)
        else $error("data phase with zero bytes left");

    // Every byte in the data phase is passed through as payload.
    a_data_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r_phase == PH_DATA) |-> (o_res.valid && o_res.kind == KIND_DATA))
        else $error("payload byte not forwarded");

    // Nothing comes out after the end of body.
    a_done_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DONE |-> !o_res.valid)
        else $error("result after end of body");

    // The end-of-body word is followed by the done phase.
    a_end_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.kind == KIND_END) |=> r_phase == PH_DONE)
        else $error("end of body without done phase");

    // The line length counter never passes the line limit.
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_MAX)
        else $error("line length past limit");

endmodule

`default_nettype wire

### rtl/chd_out.sv
// Output register of the chunked decoder with its valid/stall handshake.
// Depends on chd_pkg for t_result and the result kinds.
`default_nettype none

module chd_out
    import chd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_result    i_res,
    input  wire logic       i_stall,
    output logic            o_ready,
    output logic            o_valid,
    output logic [7:0]      o_byte_out,
    output logic [1:0]      o_kind
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic [1:0] r_kind;

    // The register takes a new word when it is empty or being drained.
    assign o_ready = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_res.valid;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_res.valid) begin
            r_byte <= i_res.byte_out;
            r_kind <= i_res.kind;
        end
    end

    assign o_valid    = r_valid;
    assign o_byte_out = r_byte;
    assign o_kind     = r_kind;

endmodule

`default_nettype wire
